>>> sv/lcd_line_timing_stat_unit_macros.svh
// Assertion macros for the display line timing unit.
// Used by the timing core and the top level; needs clk and rst_n in scope.
`ifndef LCD_LINE_TIMING_STAT_UNIT_MACROS_SVH
`define LCD_LINE_TIMING_STAT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCDLT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdlt assertion failed");

// Next-cycle implication, checked outside reset.
`define LCDLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdlt assertion failed");

`endif

>>> sv/lcdlt_pkg.sv
// Types, constants and the LY glitch table for the display line timing unit.
// No dependencies; used by every module of the unit.
package lcdlt_pkg;

    localparam logic [8:0] DOTS_PER_LINE = 9'd456;
    localparam logic [7:0] VISIBLE_LINES = 8'd144;
    localparam logic [7:0] TOTAL_LINES   = 8'd154;
    localparam logic [7:0] LAST_LINE     = TOTAL_LINES - 8'd1;
    localparam logic [8:0] OAM_DOTS      = 9'd80;
    localparam logic [8:0] XFER_DOTS     = 9'd172;
    localparam logic [8:0] GLITCH_POS    = DOTS_PER_LINE - 9'd4;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_LYC    = 2'd1;
    localparam logic [1:0] CMD_STAT   = 2'd2;
    localparam logic [1:0] CMD_ENABLE = 2'd3;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam logic [1:0] MODEL_MONO = 2'd0;

    localparam logic REG_MODEL        = 1'b0;
    localparam logic REG_DOUBLE_SPEED = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] value;
        logic       hdma_armed;
    } in_item_t;

    typedef struct packed {
        logic [7:0] line_number;
        logic [1:0] mode;
        logic       coincidence;
        logic       stat_line;
        logic       vblank_request;
        logic       stat_request;
        logic       hdma_start;
        logic       hdma_cancel;
        logic       frame_done;
    } out_item_t;

    typedef struct packed {
        logic [1:0] model;
        logic       double_speed;
    } cfg_t;

    function automatic logic [3:0] glitch_lookup(input logic [3:0] idx);
        logic [3:0] res;
        case (idx)
            4'd2:    res = 4'd2;
            4'd4:    res = 4'd4;
            4'd5:    res = 4'd4;
            4'd6:    res = 4'd6;
            4'd8:    res = 4'd8;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

endpackage

>>> sv/lcdlt_cfg.sv
// APB configuration registers (model and double speed) of the timing unit.
// Depends on lcdlt_pkg.
module lcdlt_cfg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output lcdlt_pkg::cfg_t  cfg
);

    logic [1:0] model_reg;
    logic [1:0] model_next;
    logic       ds_reg;
    logic       ds_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        model_next = model_reg;
        ds_next    = ds_reg;
        if (wr_en)
        begin
            if (paddr[2] == lcdlt_pkg::REG_MODEL)
            begin
                model_next = pwdata[1:0];
            end
            else
            begin
                ds_next = pwdata[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= 2'd0;
            ds_reg    <= 1'b0;
        end
        else
        begin
            model_reg <= model_next;
            ds_reg    <= ds_next;
        end
    end

    always_comb
    begin
        if (paddr[2] == lcdlt_pkg::REG_MODEL)
        begin
            prdata = {30'd0, model_reg};
        end
        else
        begin
            prdata = {31'd0, ds_reg};
        end
    end

    assign cfg.model        = model_reg;
    assign cfg.double_speed = ds_reg;

endmodule

>>> sv/lcdlt_timing.sv
// Line timing state and the single-pass next-state and result logic.
// Depends on lcdlt_pkg and lcd_line_timing_stat_unit_macros.svh.
`include "lcd_line_timing_stat_unit_macros.svh"

module lcdlt_timing
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcdlt_pkg::cfg_t       cfg,
    input  logic                  fire,
    input  lcdlt_pkg::in_item_t   item,
    output lcdlt_pkg::out_item_t  res
);

    logic [7:0] line_reg, line_next;
    logic [8:0] pos_reg, pos_next;
    logic [7:0] ly_reg, ly_next;
    logic [1:0] mode_reg, mode_next;
    logic       coinc_reg, coinc_next;
    logic [3:0] en_reg, en_next;
    logic [7:0] lyc_reg, lyc_next;
    logic       lcd_on_reg, lcd_on_next;
    logic       level_reg, level_next;

    logic       is_color;
    logic       color_mode;
    logic       ds;
    logic [8:0] step;
    logic [8:0] delay;
    logic [8:0] sum;
    logic       carry;
    logic [8:0] pos_wrap;
    logic [7:0] line_inc;
    logic       frame_end;
    logic       cmp;
    logic [7:0] lyc_cmp;
    logic       line_s;
    logic [3:0] gval;
    logic       vbl, hstart, hcancel, fdone, sreq;

    assign is_color   = cfg.model != lcdlt_pkg::MODEL_MONO;
    assign color_mode = cfg.model[1];
    assign ds       = cfg.double_speed;
    assign step     = ds ? 9'd2 : 9'd4;
    assign delay    = ds ? 9'd2 : (color_mode ? 9'd0 : 9'd4);
    assign sum      = pos_reg + step;
    assign carry    = sum >= lcdlt_pkg::DOTS_PER_LINE;
    assign pos_wrap = carry ? (sum - lcdlt_pkg::DOTS_PER_LINE) : sum;
    assign line_inc = line_reg + {7'd0, carry};
    assign frame_end = carry && (line_reg == lcdlt_pkg::LAST_LINE);

    always_comb
    begin
        line_next   = line_reg;
        pos_next    = pos_reg;
        ly_next     = ly_reg;
        mode_next   = mode_reg;
        coinc_next  = coinc_reg;
        en_next     = en_reg;
        lyc_next    = lyc_reg;
        lcd_on_next = lcd_on_reg;
        level_next  = level_reg;
        vbl     = 1'b0;
        hstart  = 1'b0;
        hcancel = 1'b0;
        fdone   = 1'b0;
        sreq    = 1'b0;
        cmp     = 1'b1;
        lyc_cmp = line_inc;
        line_s  = 1'b0;
        gval    = 4'd0;

        case (item.command)
            lcdlt_pkg::CMD_LYC:
            begin
                lyc_next = item.value;
            end
            lcdlt_pkg::CMD_STAT:
            begin
                en_next = item.value[6:3];
            end
            lcdlt_pkg::CMD_ENABLE:
            begin
                lcd_on_next = item.value[7];
            end
            default:
            begin
                if (!lcd_on_reg)
                begin
                    ly_next    = 8'd0;
                    mode_next  = lcdlt_pkg::MODE_HBLANK;
                    coinc_next = 1'b1;
                    hcancel    = item.hdma_armed;
                    pos_next   = pos_wrap;
                    line_next  = frame_end ? 8'd0 : line_inc;
                    fdone      = frame_end;
                    level_next = 1'b0;
                end
                else
                begin
                    ly_next = line_inc;
                    if (frame_end)
                    begin
                        pos_next  = 9'd0;
                        line_next = 8'd0;
                        if (is_color)
                        begin
                            mode_next = (delay != 9'd0) ? lcdlt_pkg::MODE_VBLANK
                                                        : lcdlt_pkg::MODE_OAM;
                        end
                        else
                        begin
                            mode_next = lcdlt_pkg::MODE_HBLANK;
                        end
                        ly_next = 8'd0;
                        lyc_cmp = 8'd0;
                        fdone   = 1'b1;
                    end
                    else
                    begin
                        pos_next  = pos_wrap;
                        line_next = line_inc;
                        if (line_inc == lcdlt_pkg::VISIBLE_LINES && pos_wrap == delay)
                        begin
                            mode_next = lcdlt_pkg::MODE_VBLANK;
                            vbl       = 1'b1;
                            line_s    = en_reg[2];
                        end
                        else if (line_inc < lcdlt_pkg::VISIBLE_LINES)
                        begin
                            if (pos_wrap == delay)
                            begin
                                mode_next = lcdlt_pkg::MODE_OAM;
                            end
                            else if (pos_wrap == 9'd0 && line_inc != 8'd0)
                            begin
                                cmp     = is_color;
                                lyc_cmp = line_inc - 8'd1;
                            end
                            else if (pos_wrap == lcdlt_pkg::OAM_DOTS + delay)
                            begin
                                mode_next = lcdlt_pkg::MODE_XFER;
                            end
                            else if (pos_wrap == lcdlt_pkg::OAM_DOTS + lcdlt_pkg::XFER_DOTS
                                                 + delay)
                            begin
                                mode_next = lcdlt_pkg::MODE_HBLANK;
                                hstart    = item.hdma_armed;
                            end
                        end
                        else if (line_inc == lcdlt_pkg::LAST_LINE)
                        begin
                            if (!is_color)
                            begin
                                if (pos_wrap == 9'd0)
                                begin
                                    cmp = 1'b0;
                                end
                                else if (pos_wrap == 9'd4)
                                begin
                                    ly_next = 8'd0;
                                    lyc_cmp = lcdlt_pkg::LAST_LINE;
                                end
                                else if (pos_wrap == 9'd8)
                                begin
                                    ly_next = 8'd0;
                                    cmp     = 1'b0;
                                end
                                else
                                begin
                                    ly_next = 8'd0;
                                    lyc_cmp = 8'd0;
                                end
                            end
                            else if (!color_mode)
                            begin
                                if (pos_wrap == 9'd0)
                                begin
                                    lyc_cmp = lcdlt_pkg::LAST_LINE - 8'd1;
                                end
                                else if (pos_wrap == 9'd8)
                                begin
                                    ly_next = 8'd0;
                                end
                                else if (pos_wrap != 9'd4)
                                begin
                                    ly_next = 8'd0;
                                    lyc_cmp = 8'd0;
                                end
                            end
                            else if (!ds)
                            begin
                                if (pos_wrap == 9'd4)
                                begin
                                    ly_next = 8'd0;
                                end
                                else if (pos_wrap != 9'd0)
                                begin
                                    ly_next = 8'd0;
                                    lyc_cmp = 8'd0;
                                end
                            end
                            else
                            begin
                                if (pos_wrap == 9'd0)
                                begin
                                    lyc_cmp = lcdlt_pkg::LAST_LINE - 8'd1;
                                end
                                else if (pos_wrap == 9'd6 || pos_wrap == 9'd8)
                                begin
                                    ly_next = 8'd0;
                                end
                                else if (pos_wrap != 9'd2 && pos_wrap != 9'd4)
                                begin
                                    ly_next = 8'd0;
                                    lyc_cmp = 8'd0;
                                end
                            end
                        end
                        else if (delay != 9'd0 && pos_wrap == 9'd0)
                        begin
                            cmp     = is_color;
                            lyc_cmp = line_inc - 8'd1;
                        end
                    end

                    coinc_next = cmp && (lyc_cmp == lyc_reg);

                    if (!line_s)
                    begin
                        case (mode_next)
                            lcdlt_pkg::MODE_HBLANK: line_s = en_reg[0];
                            lcdlt_pkg::MODE_VBLANK: line_s = en_reg[1];
                            lcdlt_pkg::MODE_OAM:    line_s = en_reg[2];
                            default:                line_s = 1'b0;
                        endcase
                        if (en_reg[3] && coinc_next)
                        begin
                            line_s = 1'b1;
                        end
                    end
                    level_next = line_s;
                    sreq       = line_s && !level_reg;

                    if (color_mode && !ds && pos_next == lcdlt_pkg::GLITCH_POS)
                    begin
                        if (ly_next[3:0] == 4'hF)
                        begin
                            gval    = lcdlt_pkg::glitch_lookup(ly_next[7:4]);
                            ly_next = {gval, 4'd0};
                        end
                        else
                        begin
                            gval    = lcdlt_pkg::glitch_lookup({1'b0, ly_next[2:0]});
                            ly_next = {ly_next[7:3], 3'd0} | {4'd0, gval};
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= 8'd0;
            pos_reg    <= 9'd0;
            ly_reg     <= 8'd0;
            mode_reg   <= 2'd0;
            coinc_reg  <= 1'b0;
            en_reg     <= 4'd0;
            lyc_reg    <= 8'd0;
            lcd_on_reg <= 1'b0;
            level_reg  <= 1'b0;
        end
        else if (fire)
        begin
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            ly_reg     <= ly_next;
            mode_reg   <= mode_next;
            coinc_reg  <= coinc_next;
            en_reg     <= en_next;
            lyc_reg    <= lyc_next;
            lcd_on_reg <= lcd_on_next;
            level_reg  <= level_next;
        end
    end

    assign res.line_number    = ly_next;
    assign res.mode           = mode_next;
    assign res.coincidence    = coinc_next;
    assign res.stat_line      = level_next;
    assign res.vblank_request = vbl;
    assign res.stat_request   = sreq;
    assign res.hdma_start     = hstart;
    assign res.hdma_cancel    = hcancel;
    assign res.frame_done     = fdone;

    `LCDLT_ASSERT_NOW(a_pos_in_line, 1'b1, pos_reg < lcdlt_pkg::DOTS_PER_LINE)
    `LCDLT_ASSERT_NOW(a_line_in_frame, 1'b1, line_reg < lcdlt_pkg::TOTAL_LINES)
    `LCDLT_ASSERT_NEXT(a_lcd_off_tick,
        fire && item.command == lcdlt_pkg::CMD_TICK && !lcd_on_reg,
        ly_reg == 8'd0 && mode_reg == lcdlt_pkg::MODE_HBLANK && coinc_reg && !level_reg)

endmodule

>>> sv/lcd_line_timing_stat_unit.sv
// An accepted item goes through the input register, then the result register, to the output.
// Throughput: one item per clock unless the output stalls while both registers are full.
// Reset clears all timing state, the registers and both pipeline stages.
// The LCD starts disabled, with LY, mode, LYC and STAT enables at zero.
// Top level of the display line timing unit.
// Depends on lcdlt_pkg, lcdlt_cfg, lcdlt_timing and the macros header.
`include "lcd_line_timing_stat_unit_macros.svh"

module lcd_line_timing_stat_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lcdlt_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lcdlt_pkg::out_item_t  out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                  s1_valid_reg, s1_valid_next;
    lcdlt_pkg::in_item_t   s1_data_reg;
    logic                  out_valid_reg, out_valid_next;
    lcdlt_pkg::out_item_t  out_data_reg;
    lcdlt_pkg::out_item_t  res;
    lcdlt_pkg::cfg_t       cfg;
    logic                  adv;
    logic                  fire;
    logic                  load;

    lcdlt_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcdlt_timing u_timing
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .item  (s1_data_reg),
        .res   (res)
    );

    assign adv      = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && adv;
    assign in_stall = s1_valid_reg && !adv;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `LCDLT_ASSERT_NEXT(a_fill_empty_result, s1_valid_reg && !out_valid_reg, out_valid_reg)
    `LCDLT_ASSERT_NEXT(a_drain_bubble, out_valid_reg && !out_stall && !s1_valid_reg,
        !out_valid_reg)

endmodule

>>> tb/lcd_line_timing_stat_unit_tb.sv
// Self-checking testbench for the display line timing and STAT unit.
// Depends on lcdlt_pkg and lcd_line_timing_stat_unit; predicts every result
// from its own timing model and compares it field by field.
module lcd_line_timing_stat_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lcdlt_pkg::*;

    localparam int LINE_DOTS  = int'(DOTS_PER_LINE);
    localparam int FRAME_DOTS = LINE_DOTS * int'(TOTAL_LINES);
    localparam int VBL_START  = LINE_DOTS * int'(VISIBLE_LINES);
    localparam int LAST_START = LINE_DOTS * int'(LAST_LINE);
    localparam int OAM_END    = int'(OAM_DOTS);
    localparam int XFER_END   = int'(OAM_DOTS) + int'(XFER_DOTS);
    localparam logic [35:0] LY_GLITCH =
        {4'd8, 4'd0, 4'd6, 4'd4, 4'd4, 4'd0, 4'd2, 4'd0, 4'd0};
    localparam logic [15:0] PHASE_MODELS =
        {2'd2, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};
    localparam logic [7:0]  PHASE_SPEEDS = 8'b0111_0000;
    localparam int NUM_PHASES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       psel = 1'b0;
    logic       penable = 1'b0;
    logic       pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic       pready;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        errors = 0;
    bit        quiet = 1'b0;
    int        send_gap;
    int        stall_gap;
    int        hold_left;
    bit        hold_done;
    int        results_seen = 0;
    int        dot_hint = 0;

    logic [1:0] cfg_model = 2'd0;
    logic       cfg_double = 1'b0;

    int         dots_q = 0;
    logic [7:0] ly_q = '0;
    logic [1:0] mode_q = MODE_HBLANK;
    logic       coin_q = 1'b0;
    logic [3:0] stat_en_q = '0;
    logic [7:0] lyc_q = '0;
    logic       lcd_on_q = 1'b0;
    logic       level_q = 1'b0;

    lcd_line_timing_stat_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [3:0] glitched_nibble(input int idx);
        return (idx < 9) ? LY_GLITCH[4*idx +: 4] : 4'd0;
    endfunction

    task automatic step_timing(input in_item_t it, output out_item_t res);
        logic       is_color;
        logic       color_mode;
        logic       lvl;
        logic       cmp;
        logic       prev;
        logic [7:0] lyc_cmp;
        int         step;
        int         dly;
        int         pos;
        int         off;
        res = '0;
        is_color = (cfg_model != MODEL_MONO);
        color_mode = cfg_model[1];
        step = cfg_double ? 2 : 4;
        dly = cfg_double ? 2 : (color_mode ? 0 : 4);
        case (it.command)
            CMD_LYC:    lyc_q = it.value;
            CMD_STAT:   stat_en_q = it.value[6:3];
            CMD_ENABLE: lcd_on_q = it.value[7];
            default:
            begin
                prev = level_q;
                lvl = 1'b0;
                cmp = 1'b1;
                dots_q += step;
                if (!lcd_on_q)
                begin
                    ly_q = '0;
                    mode_q = MODE_HBLANK;
                    coin_q = 1'b1;
                    res.hdma_cancel = it.hdma_armed;
                    if (dots_q >= FRAME_DOTS)
                    begin
                        dots_q -= FRAME_DOTS;
                        if (dots_q >= FRAME_DOTS)
                            dots_q = 0;
                        res.frame_done = 1'b1;
                    end
                    level_q = 1'b0;
                end
                else
                begin
                    ly_q = 8'(dots_q / LINE_DOTS);
                    lyc_cmp = ly_q;
                    if (dots_q >= FRAME_DOTS)
                    begin
                        dots_q = 0;
                        mode_q = is_color ? ((dly != 0) ? MODE_VBLANK : MODE_OAM)
                                          : MODE_HBLANK;
                        ly_q = '0;
                        lyc_cmp = '0;
                        res.frame_done = 1'b1;
                    end
                    else if (dots_q == VBL_START + dly)
                    begin
                        mode_q = MODE_VBLANK;
                        res.vblank_request = 1'b1;
                        lvl = stat_en_q[2];
                    end
                    else if (dots_q < VBL_START)
                    begin
                        pos = dots_q % LINE_DOTS;
                        if (pos == dly)
                        begin
                            mode_q = MODE_OAM;
                        end
                        else if (pos == 0 && dots_q != 0)
                        begin
                            cmp = is_color;
                            lyc_cmp = lyc_cmp - 8'd1;
                        end
                        else if (pos == OAM_END + dly)
                        begin
                            mode_q = MODE_XFER;
                        end
                        else if (pos == XFER_END + dly)
                        begin
                            mode_q = MODE_HBLANK;
                            res.hdma_start = it.hdma_armed;
                        end
                    end
                    else if (dots_q >= LAST_START)
                    begin
                        off = dots_q - LAST_START;
                        if (!is_color)
                        begin
                            if (off == 0)
                            begin
                                cmp = 1'b0;
                            end
                            else
                            begin
                                ly_q = '0;
                                if (off == 4)
                                    lyc_cmp = LAST_LINE;
                                else if (off == 8)
                                    cmp = 1'b0;
                                else
                                    lyc_cmp = '0;
                            end
                        end
                        else if (!color_mode)
                        begin
                            if (off == 0)
                            begin
                                lyc_cmp = LAST_LINE - 8'd1;
                            end
                            else if (off != 4)
                            begin
                                ly_q = '0;
                                if (off != 8)
                                    lyc_cmp = '0;
                            end
                        end
                        else if (!cfg_double)
                        begin
                            if (off != 0)
                            begin
                                ly_q = '0;
                                if (off != 4)
                                    lyc_cmp = '0;
                            end
                        end
                        else
                        begin
                            if (off == 0)
                            begin
                                lyc_cmp = LAST_LINE - 8'd1;
                            end
                            else if (off != 2 && off != 4)
                            begin
                                ly_q = '0;
                                if (off != 6 && off != 8)
                                    lyc_cmp = '0;
                            end
                        end
                    end
                    else if (dly != 0 && dots_q % LINE_DOTS == 0)
                    begin
                        cmp = is_color;
                        lyc_cmp = lyc_cmp - 8'd1;
                    end

                    coin_q = cmp && (lyc_cmp == lyc_q);
                    if (!lvl)
                    begin
                        case (mode_q)
                            MODE_HBLANK: lvl = stat_en_q[0];
                            MODE_VBLANK: lvl = stat_en_q[1];
                            MODE_OAM:    lvl = stat_en_q[2];
                            default:     lvl = 1'b0;
                        endcase
                        if (stat_en_q[3] && coin_q)
                            lvl = 1'b1;
                    end
                    level_q = lvl;
                    res.stat_request = lvl && !prev;

                    if (color_mode && !cfg_double && dots_q % LINE_DOTS == int'(GLITCH_POS))
                    begin
                        if (ly_q[3:0] == 4'hF)
                            ly_q = {glitched_nibble(int'(ly_q[7:4])), 4'h0};
                        else
                            ly_q = {ly_q[7:3], 3'b000}
                                 | {4'h0, glitched_nibble(int'(ly_q[2:0]))};
                    end
                end
            end
        endcase
        res.line_number = ly_q;
        res.mode = mode_q;
        res.coincidence = coin_q;
        res.stat_line = level_q;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                step_timing(in_data, want);
                expected_results.push_back(want);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 15) == 0)
                begin
                    send_gap <= $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_gap <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: line_number %0d",
                           out_data.line_number);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("line_number", want.line_number, out_data.line_number);
                    check_field("mode", 8'(want.mode), 8'(out_data.mode));
                    check_field("coincidence", 8'(want.coincidence), 8'(out_data.coincidence));
                    check_field("stat_line", 8'(want.stat_line), 8'(out_data.stat_line));
                    check_field("vblank_request", 8'(want.vblank_request),
                                8'(out_data.vblank_request));
                    check_field("stat_request", 8'(want.stat_request), 8'(out_data.stat_request));
                    check_field("hdma_start", 8'(want.hdma_start), 8'(out_data.hdma_start));
                    check_field("hdma_cancel", 8'(want.hdma_cancel), 8'(out_data.hdma_cancel));
                    check_field("frame_done", 8'(want.frame_done), 8'(out_data.frame_done));
                end
                results_seen++;
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= 150 && pending_items.size() >= 40)
            begin
                hold_done <= 1'b1;
                hold_left <= 99;
                out_stall <= 1'b1;
            end
            else if (stall_gap != 0)
            begin
                stall_gap <= stall_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                stall_gap <= $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] val, input logic armed);
        in_item_t it;
        it.command = cmd;
        it.value = val;
        it.hdma_armed = armed;
        pending_items.push_back(it);
    endtask

    task automatic push_tick(input logic armed);
        push_item(CMD_TICK, 8'($urandom), armed);
        dot_hint += cfg_double ? 2 : 4;
        if (dot_hint >= FRAME_DOTS)
            dot_hint -= FRAME_DOTS;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MODEL)
            cfg_model = data[1:0];
        else
            cfg_double = data[0];
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int         n_ticks;
        int         pos;
        int         line;
        int         noise;
        logic [7:0] lyc;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // LCD off at first: cancels, forced coincidence, then register extremes.
        push_tick(1'b1);
        push_tick(1'b0);
        push_item(CMD_LYC, 8'hFF, 1'b1);
        push_item(CMD_STAT, 8'hFF, 1'b0);
        push_item(CMD_ENABLE, 8'h7F, 1'b1);
        push_tick(1'b1);
        push_item(CMD_STAT, 8'h00, 1'b1);
        push_item(CMD_ENABLE, 8'h80, 1'b0);
        push_item(CMD_LYC, 8'h00, 1'b0);
        push_item(CMD_STAT, 8'h78, 1'b0);
        for (int k = 0; k < 8; k++)
            push_tick(k[0]);
        push_item(CMD_ENABLE, 8'h00, 1'b1);
        push_tick(1'b1);
        push_item(CMD_ENABLE, 8'hFF, 1'b0);
        push_tick(1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            write_reg(REG_MODEL, {30'd0, PHASE_MODELS[2*p +: 2]});
            write_reg(REG_DOUBLE_SPEED, {31'd0, PHASE_SPEEDS[p]});
            push_item(CMD_ENABLE, {1'b1, 7'($urandom)}, 1'($urandom));
            push_item(CMD_STAT, 8'($urandom), 1'($urandom));
            n_ticks = 85 + $urandom_range(0, 20);
            for (int k = 0; k < n_ticks; k++)
            begin
                pos = dot_hint % LINE_DOTS;
                line = dot_hint / LINE_DOTS;
                if (pos >= 400 && pos < 400 + (cfg_double ? 2 : 4))
                begin
                    if (line == int'(LAST_LINE) - 2)
                    begin
                        case ($urandom_range(0, 3))
                            0:       lyc = 8'd0;
                            1:       lyc = LAST_LINE - 8'd1;
                            2:       lyc = LAST_LINE;
                            default: lyc = VISIBLE_LINES;
                        endcase
                        push_item(CMD_LYC, lyc, 1'($urandom));
                    end
                    else if ($urandom_range(0, 2) == 0)
                    begin
                        lyc = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(line + 1);
                        push_item(CMD_LYC, lyc, 1'($urandom));
                    end
                end
                noise = $urandom_range(0, 511);
                if (noise == 0)
                    push_item(CMD_STAT, 8'($urandom), 1'($urandom));
                else if (noise == 1)
                    push_item(CMD_LYC, 8'($urandom), 1'($urandom));
                else if (noise == 2)
                    push_item(CMD_ENABLE, {1'($urandom_range(0, 7) != 0), 7'($urandom)},
                              1'($urandom));
                push_tick(1'($urandom));
            end
        end
        drain();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

endmodule
